// ===== hdl/tdv_pkg.sv =====
package tdv_pkg;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam int unsigned REG_DISCOUNT = 0;
  localparam int unsigned REG_LEARN    = 1;
  localparam int unsigned REG_LOW      = 2;
  localparam int unsigned REG_HIGH     = 3;
  localparam int unsigned REG_PERIOD   = 4;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam int unsigned SLOPE_W      = 18;
  localparam logic [7:0]  MIN_SEED     = 8'd100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_RD_NXT,
    ST_MUL1,
    ST_MUL2,
    ST_WRITE,
    ST_RS_SCAN,
    ST_RS_DIV,
    ST_RS_MAP,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture request fields
    logic rd_old;      // table read at request address
    logic rd_nxt;      // table read at next address
    logic mul1;        // discount product and error
    logic mul2;        // learning-rate product
    logic wr_upd;      // store update result
    logic wr_entry;    // store entry value
    logic count;       // advance update count
    logic scan_rd;     // read row entry for min/max
    logic scan_acc;    // fold read entry into min/max
    logic div_start;   // start slope division
    logic div_step;    // one quotient bit
    logic map_rd;      // read row entry for mapping
    logic map_wr;      // write mapped entry
    logic row_clr;     // reset row counter
    logic col_inc;     // next column
    logic row_inc;     // next row
    logic col_clr;
    logic set_flag;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic rescale_due;
    logic col_last;
    logic row_last;
    logic div_done;
  } sts_t;

endpackage

// ===== hdl/tdv_ctrl.sv =====
module tdv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  tdv_pkg::sts_t sts_i,
  output tdv_pkg::cmd_t cmd_o
);
  import tdv_pkg::*;

  state_e state_q, state_d;
  logic   scan_pend_q, scan_pend_d;
  logic   scan_last_q, scan_last_d;
  logic   map_last_q, map_last_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_pend_q <= 1'b0;
      scan_last_q <= 1'b0;
      map_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_pend_q <= scan_pend_d;
      scan_last_q <= scan_last_d;
      map_last_q  <= map_last_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    scan_pend_d   = 1'b0;
    scan_last_d   = 1'b0;
    map_last_d    = 1'b0;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RD_OLD;
        end
      end
      ST_RD_OLD: begin
        case (sts_i.op)
          OP_UPDATE: begin
            cmd_o.rd_old = 1'b1;
            state_d      = ST_RD_NXT;
          end
          OP_WRITE: begin
            cmd_o.wr_entry = 1'b1;
            state_d        = ST_OUT;
          end
          OP_READ: begin
            cmd_o.rd_old = 1'b1;
            state_d      = ST_OUT;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_RD_NXT: begin
        cmd_o.rd_nxt = 1'b1;
        state_d      = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr_upd = 1'b1;
        cmd_o.count  = 1'b1;
        if (sts_i.rescale_due) begin
          cmd_o.set_flag = 1'b1;
          cmd_o.row_clr  = 1'b1;
          cmd_o.col_clr  = 1'b1;
          state_d        = ST_RS_SCAN;
        end else begin
          state_d = ST_OUT;
        end
      end
      // read pipeline: issue read, fold on following cycle
      ST_RS_SCAN: begin
        if (scan_last_q) begin
          // last entry is folded in on the division start cycle
          cmd_o.div_start = 1'b1;
          cmd_o.col_clr   = 1'b1;
          state_d         = ST_RS_DIV;
        end else begin
          cmd_o.scan_rd  = 1'b1;
          cmd_o.scan_acc = scan_pend_q;
          scan_pend_d    = 1'b1;
          if (sts_i.col_last) scan_last_d = 1'b1;
          else cmd_o.col_inc = 1'b1;
        end
      end
      ST_RS_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.map_rd = 1'b1;
          if (sts_i.col_last) map_last_d = 1'b1;
          else cmd_o.col_inc = 1'b1;
          state_d = ST_RS_MAP;
        end
      end
      // write back the entry read last cycle and, unless it was the row's last, read the next one
      ST_RS_MAP: begin
        cmd_o.map_wr = 1'b1;
        if (map_last_q) begin
          cmd_o.col_clr = 1'b1;
          if (sts_i.row_last) begin
            state_d = ST_OUT;
          end else begin
            cmd_o.row_inc = 1'b1;
            state_d       = ST_RS_SCAN;
          end
        end else begin
          cmd_o.map_rd = 1'b1;
          if (sts_i.col_last) map_last_d = 1'b1;
          else cmd_o.col_inc = 1'b1;
        end
      end
      ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("both sides open");
  a_load_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_RD_OLD)) else $error("load lost");
`endif
endmodule

// ===== hdl/tdv_dpath.sv =====
module tdv_dpath #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_ACTIONS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tdv_pkg::cmd_t                 cmd_i,
  output tdv_pkg::sts_t                 sts_o,
  input  logic [1:0]                    operation_i,
  input  logic [3:0]                    prev_state_i,
  input  logic [1:0]                    prev_action_i,
  input  logic [3:0]                    next_state_i,
  input  logic [1:0]                    next_action_i,
  input  logic [7:0]                    reward_i,
  input  logic [7:0]                    entry_value_i,
  input  logic                          cfg_we_i,
  input  logic [tdv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                   cfg_data_i,
  output logic [7:0]                    value_out_o,
  output logic                          rescaled_o
);
  import tdv_pkg::*;

  localparam int unsigned SW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int unsigned AW    = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam int unsigned DEPTH = NUM_STATES * NUM_ACTIONS;
  localparam int unsigned ADW   = $clog2(DEPTH);

  // configuration registers
  logic signed [7:0] disc_q, eta_q;
  logic [7:0]        low_q, high_q;
  logic [15:0]       period_q, count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_q   <= '0;
      eta_q    <= '0;
      low_q    <= '0;
      high_q   <= '0;
      period_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_W'(REG_DISCOUNT): disc_q   <= cfg_data_i[7:0];
        CFG_IDX_W'(REG_LEARN):    eta_q    <= cfg_data_i[7:0];
        CFG_IDX_W'(REG_LOW):      low_q    <= cfg_data_i[7:0];
        CFG_IDX_W'(REG_HIGH):     high_q   <= cfg_data_i[7:0];
        CFG_IDX_W'(REG_PERIOD):   period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured request fields; state and action each taken modulo their count
  op_e          op_q;
  logic [ADW-1:0] here_q, there_q;
  logic [7:0]   rew_q, ent_q;

  // modulo folding as a small lookup over the field values
  function automatic logic [ADW-1:0] addr_of(logic [3:0] st, logic [1:0] ac);
    logic [SW-1:0] s;
    logic [AW-1:0] a;
    s = '0;
    a = '0;
    for (int k = 0; k < 16; k++) begin
      if (st == 4'(k)) s = SW'(k % NUM_STATES);
    end
    for (int k = 0; k < 4; k++) begin
      if (ac == 2'(k)) a = AW'(k % NUM_ACTIONS);
    end
    return ADW'(32'(s) * NUM_ACTIONS + 32'(a));
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(operation_i);
      here_q  <= addr_of(prev_state_i, prev_action_i);
      there_q <= addr_of(next_state_i, next_action_i);
      rew_q   <= reward_i;
      ent_q   <= entry_value_i;
    end
  end

  // row and column counters for rescale
  logic [SW-1:0] row_q;
  logic [AW-1:0] col_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_clr) row_q <= '0;
    else if (cmd_i.row_inc) row_q <= row_q + 1'b1;
    if (cmd_i.col_clr) col_q <= '0;
    else if (cmd_i.col_inc) col_q <= col_q + 1'b1;
  end
  logic [ADW-1:0] row_addr;
  assign row_addr = ADW'(32'(row_q) * NUM_ACTIONS + 32'(col_q));

  // value table, one read port and one write port, registered read
  logic [7:0]     mem [DEPTH];
  logic [7:0]     rd_q;
  logic [ADW-1:0] waddr, raddr;
  logic [7:0]     wdata;
  logic           we, re;
  logic [7:0]     new_val, map_val;
  logic [ADW-1:0] mac_q;

  always_comb begin
    raddr = cmd_i.rd_nxt ? there_q : (cmd_i.rd_old ? here_q : row_addr);
    re    = cmd_i.rd_old | cmd_i.rd_nxt | cmd_i.scan_rd | cmd_i.map_rd;
    we    = cmd_i.wr_upd | cmd_i.wr_entry | cmd_i.map_wr;
    waddr = cmd_i.map_wr ? mac_q : here_q;
    wdata = cmd_i.wr_entry ? ent_q : (cmd_i.wr_upd ? new_val : map_val);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_rd) mac_q <= row_addr;
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  // update arithmetic
  logic [7:0]          old_q;
  logic signed [17:0]  err_q;
  logic signed [31:0]  acc_q;
  logic signed [17:0]  err_d;
  always_comb begin
    err_d = 18'(disc_q * $signed({1'b0, rd_q})) - $signed({3'b0, old_q, 7'b0});
    if (rew_q[7]) err_d = err_d - $signed({4'b0, rew_q, 6'b0});
    else          err_d = err_d + $signed({4'b0, rew_q, 6'b0});
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_nxt) old_q <= rd_q;
    if (cmd_i.mul1) err_q <= err_d;
    if (cmd_i.mul2) acc_q <= 32'(err_q * eta_q) + $signed({10'b0, old_q, 14'b0});
  end
  assign new_val = acc_q[21:14];

  // update counter
  logic [15:0] cnt_inc;
  assign cnt_inc = count_q + 1'b1;
  assign sts_o.rescale_due = (period_q != '0) && (cnt_inc >= period_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else if (cmd_i.count) count_q <= sts_o.rescale_due || period_q == '0 ? '0 : cnt_inc;
  end

  // row min/max scan
  logic [7:0] hi_q, lo_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.col_clr && !cmd_i.div_start) begin
      hi_q <= '0;
      lo_q <= MIN_SEED;
    end else if (cmd_i.scan_acc) begin
      if (rd_q > hi_q) hi_q <= rd_q;
      if (rd_q < lo_q) lo_q <= rd_q;
    end
  end
  // fold the final entry in on the division start cycle
  logic [7:0] hi_f, lo_f;
  assign hi_f = (rd_q > hi_q) ? rd_q : hi_q;
  assign lo_f = (rd_q < lo_q) ? rd_q : lo_q;

  // restoring divider, one quotient bit per cycle
  logic [7:0]         dhi_q, dlo_q, den_q;
  logic [SLOPE_W-1:0] quo_q;
  logic [8:0]         rem_q;
  logic [4:0]         dcnt_q;
  logic [7:0]         span;
  logic [9:0]         trial;
  assign span  = (high_q > low_q) ? high_q - low_q : 8'd0;
  assign trial = {rem_q, quo_q[SLOPE_W-1]} ;
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dhi_q  <= hi_f;
      dlo_q  <= lo_f;
      den_q  <= hi_f - lo_f;
      quo_q  <= {span, 10'b0};
      rem_q  <= '0;
      dcnt_q <= 5'(SLOPE_W);
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (trial >= {2'b0, den_q}) begin
        rem_q <= 9'(trial - {2'b0, den_q});
        quo_q <= {quo_q[SLOPE_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[8:0];
        quo_q <= {quo_q[SLOPE_W-2:0], 1'b0};
      end
    end
  end
  assign sts_o.div_done = (dcnt_q == '0);

  // linear map of one entry
  logic signed [28:0] t;
  always_comb begin
    t = $signed({1'b0, quo_q}) * ($signed({1'b0, rd_q}) - $signed({1'b0, dhi_q}))
        + $signed({11'b0, high_q, 10'b0});
    if (dhi_q == dlo_q || rd_q == dhi_q) map_val = high_q;
    else if (rd_q == dlo_q)              map_val = low_q;
    else                                 map_val = t[17:10];
  end

  // result register; a read is held once its table data has arrived
  logic [7:0] vout_q;
  logic       flag_q;
  logic       rd_out_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vout_q <= '0;
    end else if (cmd_i.wr_upd) begin
      vout_q <= new_val;
    end else if (cmd_i.wr_entry) begin
      vout_q <= ent_q;
    end else if (rd_out_q) begin
      vout_q <= rd_q;
    end
    if (cmd_i.load) flag_q <= 1'b0;
    else if (cmd_i.set_flag) flag_q <= 1'b1;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_out_q <= 1'b0;
    else rd_out_q <= cmd_i.rd_old && op_q == OP_READ;
  end
  assign value_out_o = rd_out_q ? rd_q : vout_q;
  assign rescaled_o  = flag_q;

  assign sts_o.op       = op_q;
  assign sts_o.col_last = (32'(col_q) == NUM_ACTIONS - 1);
  assign sts_o.row_last = (32'(row_q) == NUM_STATES - 1);

`ifndef SYNTHESIS
  a_count_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count |=> (count_q == '0 || count_q < $past(period_q)))
    else $error("count past period");
  a_no_two_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.wr_upd && cmd_i.map_wr)) else $error("write clash");
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.map_wr |-> (dhi_q >= dlo_q)) else $error("bad row range");
`endif
endmodule

// ===== hdl/td_value_table_update_rescale_unit.sv =====
// Value table with a fixed-point TD update and periodic per-row rescale.
// One request at a time: a write or read takes one table access before its result, an
// update reads both entries in turn through the single read port and applies two
// registered multiplies before its write. An update that triggers a rescale adds a
// sweep of every row, the 18-step slope divider dominating. Results wait in an output
// register until taken.
// tdata in: operation, prev_state, prev_action, next_state, next_action,
// reward, entry_value from bit 0. tdata out: value_out; tuser out: rescaled.
module td_value_table_update_rescale_unit #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned NUM_ACTIONS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // op, ps, pa, ns, na, rew, val
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // value_out
  output logic                          m_axis_tuser,  // rescaled
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tdv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import tdv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tdv_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .sts_i(sts), .cmd_o(cmd)
  );

  tdv_dpath #(.NUM_STATES(NUM_STATES), .NUM_ACTIONS(NUM_ACTIONS)) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .operation_i(s_axis_tdata[1:0]),
    .prev_state_i(s_axis_tdata[5:2]),
    .prev_action_i(s_axis_tdata[7:6]),
    .next_state_i(s_axis_tdata[11:8]),
    .next_action_i(s_axis_tdata[13:12]),
    .reward_i(s_axis_tdata[21:14]),
    .entry_value_i(s_axis_tdata[29:22]),
    .cfg_we_i(cfg_valid_i),
    .cfg_idx_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .value_out_o(m_axis_tdata),
    .rescaled_o(m_axis_tuser)
  );
endmodule

// ===== tb/td_value_table_update_rescale_unit_test.sv =====
`timescale 1ns / 1ps

module td_value_table_update_rescale_unit_test;
  import tdv_pkg::*;

  localparam int unsigned ROWS      = 16;
  localparam int unsigned COLS      = 4;
  localparam int unsigned CYCLE_CAP = 4000000;

  typedef struct packed {
    logic [7:0] value;
    logic       rescaled;
  } table_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  td_value_table_update_rescale_unit #(
    .NUM_STATES (ROWS),
    .NUM_ACTIONS(COLS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // predicted block state
  logic [7:0]        q_table [ROWS*COLS];
  logic [15:0]       update_cnt;
  logic signed [7:0] gamma_q7;
  logic signed [7:0] eta_q7;
  logic [7:0]        target_low;
  logic [7:0]        target_high;
  logic [15:0]       sweep_period;

  table_result_t expected_results[$];
  int unsigned   mismatches = 0;
  int unsigned   cycles = 0;
  int unsigned   hold_left = 0;
  int unsigned   burst_left = 0;
  bit            gaps_on = 1'b1;

  // clock and run limit
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // linear per-row remap of the whole table
  function automatic void rescale_rows();
    int span;
    int hi;
    int lo;
    int w;
    longint slope;
    longint t;
    span = (target_high > target_low) ? target_high - target_low : 0;
    for (int s = 0; s < ROWS; s++) begin
      hi = 0;
      lo = 100;
      for (int a = 0; a < COLS; a++) begin
        if (q_table[s*COLS+a] > hi) hi = q_table[s*COLS+a];
        if (q_table[s*COLS+a] < lo) lo = q_table[s*COLS+a];
      end
      if (hi == lo) begin
        for (int a = 0; a < COLS; a++) q_table[s*COLS+a] = target_high;
      end else begin
        slope = (longint'(span) <<< 10) / (hi - lo);
        for (int a = 0; a < COLS; a++) begin
          w = q_table[s*COLS+a];
          if (w == hi) begin
            q_table[s*COLS+a] = target_high;
          end else if (w == lo) begin
            q_table[s*COLS+a] = target_low;
          end else begin
            t = slope * (w - hi) + (longint'(target_high) <<< 10);
            if (t < 0) t = 0;
            q_table[s*COLS+a] = 8'(t >>> 10);
          end
        end
      end
    end
  endfunction

  // expected result of one request, advancing the predicted state
  function automatic table_result_t predict_value(input logic [31:0] req);
    op_e           op;
    int            here;
    int            there;
    int            old_v;
    int            nxt_v;
    int            rew;
    int            err;
    int            acc;
    table_result_t r;
    op    = op_e'(req[1:0]);
    here  = req[5:2] * COLS + req[7:6];
    there = req[11:8] * COLS + req[13:12];
    rew   = req[21:14];
    r     = '0;
    case (op)
      OP_UPDATE: begin
        old_v = q_table[here];
        nxt_v = q_table[there];
        err = int'(gamma_q7) * nxt_v - old_v * 128;
        if (rew > 127) err -= rew * 64;
        else err += rew * 64;
        acc = err * int'(eta_q7) + old_v * 16384;
        r.value = 8'(acc >>> 14);
        q_table[here] = r.value;
        if (sweep_period == 0) begin
          update_cnt = '0;
        end else begin
          update_cnt = update_cnt + 16'd1;
          if (update_cnt >= sweep_period) begin
            update_cnt = '0;
            rescale_rows();
            r.rescaled = 1'b1;
          end
        end
      end
      OP_WRITE: begin
        r.value = req[29:22];
        q_table[here] = r.value;
      end
      OP_READ: r.value = q_table[here];
      default: r = '0;
    endcase
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, -1);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata !== want.value) report_mismatch("value_out", m_axis_tdata, want.value);
        if (m_axis_tuser !== want.rescaled)
          report_mismatch("rescaled", m_axis_tuser, want.rescaled);
      end
    end
  end

  // receiver stalls: long hold-off first, else a pattern that steps through always ready and three random ready rates
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case ((cycles / 64) % 4)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // one request; valid stays high until the next gap or request
  task automatic send_request(input op_e op, input logic [3:0] ps, input logic [1:0] pa,
                              input logic [3:0] ns, input logic [1:0] na,
                              input logic [7:0] rew, input logic [7:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, val, rew, na, ns, pa, ps, op};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(predict_value(s_axis_tdata));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input int unsigned idx, input logic [15:0] data);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = CFG_IDX_W'(idx);
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DISCOUNT: gamma_q7 = data[7:0];
      REG_LEARN:    eta_q7 = data[7:0];
      REG_LOW:      target_low = data[7:0];
      REG_HIGH:     target_high = data[7:0];
      REG_PERIOD:   sweep_period = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_all(input logic [7:0] g, input logic [7:0] e, input logic [7:0] lo,
                         input logic [7:0] hi, input logic [15:0] per);
    write_reg(REG_DISCOUNT, {8'h00, g});
    write_reg(REG_LEARN, {8'h00, e});
    write_reg(REG_LOW, {8'h00, lo});
    write_reg(REG_HIGH, {8'h00, hi});
    write_reg(REG_PERIOD, per);
  endtask

  task automatic send_random(input int unsigned n);
    int unsigned pick;
    op_e op;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      op = (pick < 60) ? OP_UPDATE : (pick < 78) ? OP_READ : (pick < 95) ? OP_WRITE : OP_NONE;
      send_request(op, 4'($urandom), 2'($urandom), 4'($urandom), 2'($urandom),
                   8'($urandom), 8'($urandom));
    end
  endtask

  // every entry gets a value so no read ever hits an unwritten one
  task automatic test_table_fill();
    for (int i = 0; i < ROWS*COLS; i++)
      send_request(OP_WRITE, 4'(i / COLS), 2'(i % COLS), 4'd0, 2'd0, 8'd0,
                   (i == 0) ? 8'd0 : (i == 1) ? 8'd255 : 8'($urandom));
  endtask

  task automatic test_directed();
    set_all(8'h7f, 8'h80, 8'd0, 8'd255, 16'd0);
    send_request(OP_UPDATE, 4'd0, 2'd0, 4'd0, 2'd1, 8'd0, 8'd0);
    send_request(OP_UPDATE, 4'd15, 2'd3, 4'd0, 2'd1, 8'd127, 8'd0);
    send_request(OP_UPDATE, 4'd3, 2'd2, 4'd15, 2'd3, 8'd128, 8'd0);
    send_request(OP_UPDATE, 4'd7, 2'd1, 4'd7, 2'd1, 8'd255, 8'd255);
    send_request(OP_NONE, 4'd15, 2'd3, 4'd15, 2'd3, 8'd255, 8'd255);
    send_request(OP_READ, 4'd15, 2'd3, 4'd0, 2'd0, 8'd0, 8'd0);
    set_all(8'h80, 8'h7f, 8'd10, 8'd200, 16'd1);
    // a flat row and a row above the min seed
    for (int a = 0; a < COLS; a++) begin
      send_request(OP_WRITE, 4'd5, 2'(a), 4'd0, 2'd0, 8'd0, 8'd42);
      send_request(OP_WRITE, 4'd6, 2'(a), 4'd0, 2'd0, 8'd0, 8'(150 + 30 * a));
    end
    send_request(OP_UPDATE, 4'd1, 2'd1, 4'd2, 2'd2, 8'd64, 8'd0);
    send_request(OP_READ, 4'd5, 2'd0, 4'd0, 2'd0, 8'd0, 8'd0);
    send_request(OP_READ, 4'd6, 2'd1, 4'd0, 2'd0, 8'd0, 8'd0);
    // low above high collapses the slope
    write_reg(REG_LOW, 16'd255);
    write_reg(REG_HIGH, 16'd0);
    send_request(OP_UPDATE, 4'd9, 2'd0, 4'd9, 2'd3, 8'd200, 8'd0);
    send_request(OP_READ, 4'd9, 2'd2, 4'd0, 2'd0, 8'd0, 8'd0);
  endtask

  task automatic test_random_phases();
    logic [15:0] per;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 4))
        0: per = 16'd0;
        1: per = 16'd65535;
        2: per = 16'($urandom_range(1, 4));
        default: per = 16'($urandom_range(5, 40));
      endcase
      set_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), per);
      send_random(150);
    end
  endtask

  task automatic test_output_backpressure();
    set_all(8'h40, 8'h20, 8'd5, 8'd250, 16'd3);
    gaps_on = 1'b0;
    @(posedge clk_i);
    hold_left = 400;
    send_random(40);
    gaps_on = 1'b1;
    drain_results();
    send_random(40);
  endtask

  initial begin
    update_cnt   = '0;
    gamma_q7     = '0;
    eta_q7       = '0;
    target_low   = '0;
    target_high  = '0;
    sweep_period = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_table_fill();
    test_directed();
    test_random_phases();
    test_output_backpressure();
    drain_results();
    repeat (600) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
